### hdl/vdta_pkg.sv
package vdta_pkg;

	localparam int AMPLITUDE_LIMIT_DEF = 250;
	localparam int HOLDOFF_STEP_DEF    = 40;

	localparam logic [15:0] HOLDOFF_RESET = 16'd80;

	localparam logic [7:0] UPPER_THRESHOLD_RST = 8'd30;
	localparam logic [7:0] LOWER_THRESHOLD_RST = 8'd15;
	localparam logic [7:0] REQUIRED_RUN_RST    = 8'd4;
	localparam logic [7:0] HOLDOFF_UNITS_RST   = 8'd5;

	typedef enum logic [1:0] {
		MODE_WAIT = 2'd0,
		MODE_DET  = 2'd1,
		MODE_ERR  = 2'd2
	} mode_t;

	typedef struct packed {
		logic [7:0] upper_threshold;
		logic [7:0] lower_threshold;
		logic [7:0] required_run;
		logic [7:0] holdoff_units;
	} cfg_t;

	typedef struct packed {
		logic counted;
		logic active;
	} axis_flags_t;

	function automatic logic [16:0] mag16(input logic signed [15:0] v);
		logic [16:0] ext;
		ext = {v[15], v};
		return v[15] ? (17'd0 - ext) : ext;
	endfunction

endpackage

### hdl/vehicle_detect_three_axis.sv
// Channel   Handshake            Payload
// input     in_valid / in_stall  sample_x/y/z, base_x/y/z (16 bit signed)
// output    out_valid/out_stall  total_x/y/z/combined, mode_x/y/z, error_bits, peak_x/y/z
// config    wr_en                wr_index (2 bit), wr_data (8 bit)
//
// One beat per cycle is sustained while out_stall is low; results are registered.
// The input register takes a beat while the previous result waits in the output stage.
// The axis state registers double as the output payload, so they only advance when the
// output stage is free or being emptied, and a stalled result holds.
// Reset loads the configuration defaults, clears all counters and puts every axis in
// waiting with a holdoff of eighty beats.
module vehicle_detect_three_axis #(
	parameter int AMPLITUDE_LIMIT = vdta_pkg::AMPLITUDE_LIMIT_DEF,
	parameter int HOLDOFF_STEP    = vdta_pkg::HOLDOFF_STEP_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [7:0]         wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] sample_x,
	input  logic signed [15:0] sample_y,
	input  logic signed [15:0] sample_z,
	input  logic signed [15:0] base_x,
	input  logic signed [15:0] base_y,
	input  logic signed [15:0] base_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        total_x,
	output logic [31:0]        total_y,
	output logic [31:0]        total_z,
	output logic [31:0]        total_combined,
	output logic [1:0]         mode_x,
	output logic [1:0]         mode_y,
	output logic [1:0]         mode_z,
	output logic [2:0]         error_bits,
	output logic signed [15:0] peak_x,
	output logic signed [15:0] peak_y,
	output logic signed [15:0] peak_z
);
	import vdta_pkg::*;

	localparam logic [1:0] REG_UPPER    = 2'd0;
	localparam logic [1:0] REG_LOWER    = 2'd1;
	localparam logic [1:0] REG_REQUIRED = 2'd2;
	localparam logic [1:0] REG_HOLDOFF  = 2'd3;

	cfg_t               cfg_q;
	logic               valid_s1;
	logic signed [15:0] smp_s1 [3];
	logic signed [15:0] bas_s1 [3];
	logic               out_valid_q;
	logic               advance, accept;
	axis_flags_t        flags [3];
	mode_t              mode [3];
	logic signed [15:0] peak [3];
	logic [2:0]         err;
	logic [31:0]        tot_q [4];
	logic               any_count, all_agree;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.upper_threshold <= UPPER_THRESHOLD_RST;
			cfg_q.lower_threshold <= LOWER_THRESHOLD_RST;
			cfg_q.required_run    <= REQUIRED_RUN_RST;
			cfg_q.holdoff_units   <= HOLDOFF_UNITS_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_UPPER:    cfg_q.upper_threshold <= wr_data;
				REG_LOWER:    cfg_q.lower_threshold <= wr_data;
				REG_REQUIRED: cfg_q.required_run    <= wr_data;
				REG_HOLDOFF:  cfg_q.holdoff_units   <= wr_data;
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			smp_s1[0] <= sample_x;
			smp_s1[1] <= sample_y;
			smp_s1[2] <= sample_z;
			bas_s1[0] <= base_x;
			bas_s1[1] <= base_y;
			bas_s1[2] <= base_z;
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_axis
		vdta_axis #(
			.AMPLITUDE_LIMIT(AMPLITUDE_LIMIT),
			.HOLDOFF_STEP   (HOLDOFF_STEP)
		) u_axis (
			.clk   (clk),
			.arst_n(arst_n),
			.step  (advance),
			.cfg   (cfg_q),
			.sample(smp_s1[a]),
			.base  (bas_s1[a]),
			.flags (flags[a]),
			.mode  (mode[a]),
			.peak  (peak[a]),
			.err   (err[a])
		);
	end

	assign any_count = flags[0].counted | flags[1].counted | flags[2].counted;
	assign all_agree = (flags[0].counted | flags[0].active)
		& (flags[1].counted | flags[1].active)
		& (flags[2].counted | flags[2].active);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				tot_q[i] <= 32'd0;
			end
		end else if (advance) begin
			for (int i = 0; i < 3; i++) begin
				tot_q[i] <= tot_q[i] + 32'(flags[i].counted);
			end
			tot_q[3] <= tot_q[3] + 32'(any_count & all_agree);
		end
	end

	assign out_valid      = out_valid_q;
	assign total_x        = tot_q[0];
	assign total_y        = tot_q[1];
	assign total_z        = tot_q[2];
	assign total_combined = tot_q[3];
	assign mode_x         = mode[0];
	assign mode_y         = mode[1];
	assign mode_z         = mode[2];
	assign error_bits     = err;
	assign peak_x         = peak[0];
	assign peak_y         = peak[1];
	assign peak_z         = peak[2];

endmodule

### hdl/vdta_axis.sv
module vdta_axis #(
	parameter int AMPLITUDE_LIMIT = vdta_pkg::AMPLITUDE_LIMIT_DEF,
	parameter int HOLDOFF_STEP    = vdta_pkg::HOLDOFF_STEP_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  vdta_pkg::cfg_t        cfg,
	input  logic signed [15:0]    sample,
	input  logic signed [15:0]    base,
	output vdta_pkg::axis_flags_t flags,
	output vdta_pkg::mode_t       mode,
	output logic signed [15:0]    peak,
	output logic                  err
);
	import vdta_pkg::*;

	localparam logic [16:0] AMP_LIM   = 17'(AMPLITUDE_LIMIT);
	localparam logic [15:0] HOLD_STEP = 16'(HOLDOFF_STEP);

	mode_t              mode_q, mode_n;
	logic [15:0]        hold_q, hold_n;
	logic [7:0]         run_q, run_n, run_inc;
	logic signed [15:0] peak_q, peak_n;
	logic               err_q, err_n;
	logic [16:0]        smag, bmag, diff;
	logic [15:0]        reload;
	logic               counted;

	assign smag    = mag16(sample);
	assign bmag    = mag16(base);
	assign diff    = (smag >= bmag) ? (smag - bmag) : (bmag - smag);
	assign run_inc = (run_q == 8'hFF) ? run_q : run_q + 8'd1;
	assign reload  = 16'(cfg.holdoff_units) * HOLD_STEP;

	always_comb begin
		mode_n  = mode_q;
		hold_n  = hold_q;
		run_n   = run_q;
		counted = 1'b0;
		priority if (diff > AMP_LIM) begin
			mode_n = MODE_ERR;
		end else if (hold_q != 16'd0) begin
			hold_n = hold_q - 16'd1;
			run_n  = 8'd0;
		end else if (mode_q == MODE_WAIT) begin
			if (diff > {9'd0, cfg.upper_threshold}) begin
				run_n = run_inc;
				if (run_inc >= cfg.required_run) begin
					mode_n  = MODE_DET;
					counted = 1'b1;
				end
			end else begin
				run_n = 8'd0;
			end
		end else begin
			if (diff < {9'd0, cfg.lower_threshold}) begin
				run_n = run_inc;
				if (run_inc >= cfg.required_run) begin
					mode_n = MODE_WAIT;
				end
			end else begin
				run_n = 8'd0;
			end
		end
		if (mode_n != mode_q && mode_n != MODE_ERR) begin
			hold_n = reload;
		end
	end

	always_comb begin
		unique case (mode_n)
			MODE_WAIT: peak_n = '0;
			MODE_DET:  peak_n = (mag16(peak_q) < smag) ? sample : peak_q;
			default:   peak_n = peak_q;
		endcase
		err_n = err_q | (mode_n == MODE_ERR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_WAIT;
			hold_q <= HOLDOFF_RESET;
			run_q  <= 8'd0;
			peak_q <= '0;
			err_q  <= 1'b0;
		end else if (step) begin
			mode_q <= mode_n;
			hold_q <= hold_n;
			run_q  <= run_n;
			peak_q <= peak_n;
			err_q  <= err_n;
		end
	end

	assign flags.counted = counted;
	assign flags.active  = (mode_n != MODE_WAIT);
	assign mode          = mode_q;
	assign peak          = peak_q;
	assign err           = err_q;

	a_count_from_wait: assert property (@(posedge clk) disable iff (!arst_n)
		step && counted |-> mode_q == MODE_WAIT)
		else $error("vehicle counted on an axis that was not waiting");

	a_peak_clear_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_WAIT |-> peak_q == 16'sd0)
		else $error("peak not cleared while waiting");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_ERR |-> err_q)
		else $error("error mode without sticky error bit");

	a_hold_without_step: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(mode_q) && $stable(hold_q) && $stable(run_q))
		else $error("axis state changed without a beat");

endmodule

### dv/testbench.sv
module testbench;
	import vdta_pkg::*;

	localparam logic [1:0] CFG_UPPER_THRESHOLD = 2'd0;
	localparam logic [1:0] CFG_LOWER_THRESHOLD = 2'd1;
	localparam logic [1:0] CFG_REQUIRED_RUN    = 2'd2;
	localparam logic [1:0] CFG_HOLDOFF_UNITS   = 2'd3;

	typedef struct packed {
		logic [2:0][15:0] smp;
		logic [2:0][15:0] base;
	} mag_reading_t;

	typedef struct packed {
		logic [3:0][31:0] totals;
		logic [2:0][1:0]  modes;
		logic [2:0]       errs;
		logic [2:0][15:0] peaks;
	} detector_status_t;

	typedef enum int {
		SCENE_QUIET,
		SCENE_MID,
		SCENE_PASS,
		SCENE_FAULT,
		SCENE_NOISE
	} scene_t;

	class detection_tracker;
		logic [7:0]       upper;
		logic [7:0]       lower;
		logic [7:0]       run_req;
		logic [7:0]       holdoff_units;
		mode_t            mode [3];
		logic [15:0]      holdoff_left [3];
		logic [7:0]       run [3];
		logic [15:0]      peak [3];
		logic [31:0]      totals [4];
		logic [2:0]       sticky;
		detector_status_t pending [$];
		int               mismatches;

		function new();
			upper         = UPPER_THRESHOLD_RST;
			lower         = LOWER_THRESHOLD_RST;
			run_req       = REQUIRED_RUN_RST;
			holdoff_units = HOLDOFF_UNITS_RST;
			for (int a = 0; a < 3; a++) begin
				mode[a]         = MODE_WAIT;
				holdoff_left[a] = HOLDOFF_RESET;
				run[a]          = '0;
				peak[a]         = '0;
			end
			for (int a = 0; a < 4; a++) totals[a] = '0;
			sticky     = '0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [7:0] val);
			case (idx)
				CFG_UPPER_THRESHOLD: upper = val;
				CFG_LOWER_THRESHOLD: lower = val;
				CFG_REQUIRED_RUN:    run_req = val;
				CFG_HOLDOFF_UNITS:   holdoff_units = val;
			endcase
		endfunction

		function bit advance_axis(int a, logic [15:0] s_raw, logic [15:0] b_raw);
			int    sm;
			int    bm;
			int    pm;
			int    diff;
			mode_t prior;
			bit    counted;
			sm = $signed(s_raw);
			bm = $signed(b_raw);
			pm = $signed(peak[a]);
			if (sm < 0) sm = -sm;
			if (bm < 0) bm = -bm;
			if (pm < 0) pm = -pm;
			diff = sm - bm;
			if (diff < 0) diff = -diff;
			prior   = mode[a];
			counted = 1'b0;
			if (diff > AMPLITUDE_LIMIT_DEF) begin
				mode[a] = MODE_ERR;
			end else if (holdoff_left[a] != 0) begin
				holdoff_left[a]--;
				run[a] = '0;
			end else if (mode[a] == MODE_WAIT) begin
				if (diff > int'(upper)) begin
					if (run[a] != 8'hFF) run[a]++;
					if (run[a] >= run_req) begin
						mode[a] = MODE_DET;
						counted = 1'b1;
					end
				end else begin
					run[a] = '0;
				end
			end else begin
				if (diff < int'(lower)) begin
					if (run[a] != 8'hFF) run[a]++;
					if (run[a] >= run_req) mode[a] = MODE_WAIT;
				end else begin
					run[a] = '0;
				end
			end
			if (mode[a] != prior && mode[a] != MODE_ERR)
				holdoff_left[a] = 16'(holdoff_units * HOLDOFF_STEP_DEF);
			if (mode[a] == MODE_WAIT) begin
				peak[a] = '0;
			end else if (mode[a] == MODE_DET) begin
				if (pm < sm) peak[a] = s_raw;
			end else begin
				sticky[a] = 1'b1;
			end
			return counted;
		endfunction

		function void take_reading(mag_reading_t r);
			bit [2:0]         hit;
			bit               all_ok;
			detector_status_t st;
			all_ok = 1'b1;
			for (int a = 0; a < 3; a++) begin
				hit[a] = advance_axis(a, r.smp[a], r.base[a]);
				if (hit[a]) totals[a]++;
			end
			for (int a = 0; a < 3; a++)
				if (!hit[a] && mode[a] == MODE_WAIT) all_ok = 1'b0;
			if (|hit && all_ok) totals[3]++;
			for (int a = 0; a < 4; a++) st.totals[a] = totals[a];
			for (int a = 0; a < 3; a++) begin
				st.modes[a] = mode[a];
				st.peaks[a] = peak[a];
			end
			st.errs = sticky;
			pending.push_back(st);
		endfunction

		function void compare_field(string what, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch on %s: expected %0h, got %0h", what, want, got);
			end
		endfunction

		function void check_status(detector_status_t act);
			detector_status_t exp;
			string            tag [4];
			tag = '{"x", "y", "z", "combined"};
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result beat with nothing pending: %h", act);
				return;
			end
			exp = pending.pop_front();
			for (int a = 0; a < 4; a++)
				compare_field($sformatf("total_%s", tag[a]), exp.totals[a], act.totals[a]);
			for (int a = 0; a < 3; a++) begin
				compare_field($sformatf("mode_%s", tag[a]), exp.modes[a], act.modes[a]);
				compare_field($sformatf("peak_%s", tag[a]), exp.peaks[a], act.peaks[a]);
			end
			compare_field("error_bits", exp.errs, act.errs);
		endfunction

		function int failures();
			return mismatches + pending.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               wr_en = 1'b0;
	logic [1:0]         wr_index = '0;
	logic [7:0]         wr_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [15:0] sample_x = '0;
	logic signed [15:0] sample_y = '0;
	logic signed [15:0] sample_z = '0;
	logic signed [15:0] base_x = '0;
	logic signed [15:0] base_y = '0;
	logic signed [15:0] base_z = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [31:0]        total_x;
	logic [31:0]        total_y;
	logic [31:0]        total_z;
	logic [31:0]        total_combined;
	logic [1:0]         mode_x;
	logic [1:0]         mode_y;
	logic [1:0]         mode_z;
	logic [2:0]         error_bits;
	logic signed [15:0] peak_x;
	logic signed [15:0] peak_y;
	logic signed [15:0] peak_z;

	detection_tracker sb = new();
	int               burst_left;

	vehicle_detect_three_axis DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample_x       (sample_x),
		.sample_y       (sample_y),
		.sample_z       (sample_z),
		.base_x         (base_x),
		.base_y         (base_y),
		.base_z         (base_z),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.total_x        (total_x),
		.total_y        (total_y),
		.total_z        (total_z),
		.total_combined (total_combined),
		.mode_x         (mode_x),
		.mode_y         (mode_y),
		.mode_z         (mode_z),
		.error_bits     (error_bits),
		.peak_x         (peak_x),
		.peak_y         (peak_y),
		.peak_z         (peak_z)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		detector_status_t seen;
		mag_reading_t     got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				seen.totals[0] = total_x;
				seen.totals[1] = total_y;
				seen.totals[2] = total_z;
				seen.totals[3] = total_combined;
				seen.modes[0]  = mode_x;
				seen.modes[1]  = mode_y;
				seen.modes[2]  = mode_z;
				seen.errs      = error_bits;
				seen.peaks[0]  = peak_x;
				seen.peaks[1]  = peak_y;
				seen.peaks[2]  = peak_z;
				sb.check_status(seen);
			end
			if (in_valid && !in_stall) begin
				got.smp[0]  = sample_x;
				got.smp[1]  = sample_y;
				got.smp[2]  = sample_z;
				got.base[0] = base_x;
				got.base[1] = base_y;
				got.base[2] = base_z;
				sb.take_reading(got);
			end
		end
	end

	// The first stretch after reset is a long hold so the block fills and stalls its input.
	initial begin
		int kind;
		int span;
		wait (arst_n);
		@(posedge clk);
		out_stall <= 1'b1;
		repeat (60) @(posedge clk);
		forever begin
			kind = $urandom_range(0, 9);
			span = $urandom_range(5, 60);
			if (kind <= 3) begin
				out_stall <= 1'b0;
				repeat (span) @(posedge clk);
			end else if (kind <= 8) begin
				repeat (span) begin
					if (kind == 8) out_stall <= ($urandom_range(0, 3) != 0);
					else out_stall <= ($urandom_range(0, 2) == 0);
					@(posedge clk);
				end
			end else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(20, 80)) @(posedge clk);
			end
		end
	end

	function automatic mag_reading_t reading_of(int sx, int sy, int sz, int bx, int by, int bz);
		mag_reading_t r;
		r.smp[0]  = 16'(sx);
		r.smp[1]  = 16'(sy);
		r.smp[2]  = 16'(sz);
		r.base[0] = 16'(bx);
		r.base[1] = 16'(by);
		r.base[2] = 16'(bz);
		return r;
	endfunction

	function automatic scene_t pick_scene();
		int w;
		w = $urandom_range(0, 99);
		if (w < 35) return SCENE_QUIET;
		if (w < 70) return SCENE_PASS;
		if (w < 80) return SCENE_MID;
		if (w < 88) return SCENE_FAULT;
		return SCENE_NOISE;
	endfunction

	// Returns {sample, base} for one axis whose magnitude difference suits the scene.
	function automatic logic [31:0] axis_pair(scene_t sc);
		logic [15:0] b;
		int          bm;
		int          d;
		int          lo;
		int          hi;
		int          m;
		bit          neg;
		b = 16'($urandom);
		if (sc == SCENE_NOISE) return {16'($urandom), b};
		bm = $signed(b);
		if (bm < 0) bm = -bm;
		lo = (sb.lower < sb.upper) ? sb.lower : sb.upper;
		hi = (sb.lower < sb.upper) ? sb.upper : sb.lower;
		if (lo > AMPLITUDE_LIMIT_DEF) lo = AMPLITUDE_LIMIT_DEF;
		if (hi > AMPLITUDE_LIMIT_DEF) hi = AMPLITUDE_LIMIT_DEF;
		case (sc)
			SCENE_QUIET: d = (sb.lower == 0) ? 0 : $urandom_range(0, sb.lower - 1);
			SCENE_MID:   d = $urandom_range(lo, hi);
			SCENE_PASS:  d = (sb.upper >= AMPLITUDE_LIMIT_DEF) ? AMPLITUDE_LIMIT_DEF :
					$urandom_range(sb.upper + 1, AMPLITUDE_LIMIT_DEF);
			default:     d = ($urandom_range(0, 3) == 0) ? AMPLITUDE_LIMIT_DEF + 1 :
					$urandom_range(AMPLITUDE_LIMIT_DEF + 2, 32767);
		endcase
		if (bm + d <= 32767) begin
			m = bm + d;
		end else if (bm >= d) begin
			m = bm - d;
		end else begin
			b = '0;
			m = d;
		end
		neg = $urandom_range(0, 1);
		if (m > 32767) neg = 1'b1;
		return {16'(neg ? -m : m), b};
	endfunction

	task automatic offer_reading(input mag_reading_t r);
		int gap;
		in_valid <= 1'b1;
		sample_x <= r.smp[0];
		sample_y <= r.smp[1];
		sample_z <= r.smp[2];
		base_x   <= r.base[0];
		base_y   <= r.base[1];
		base_z   <= r.base[2];
		@(posedge clk);
		while (in_stall) @(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 25) : $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 60);
		end
	endtask

	task automatic settle_block();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic program_cfg(input int up, input int low, input int req, input int units);
		settle_block();
		write_reg(CFG_UPPER_THRESHOLD, 8'(up));
		write_reg(CFG_LOWER_THRESHOLD, 8'(low));
		write_reg(CFG_REQUIRED_RUN, 8'(req));
		write_reg(CFG_HOLDOFF_UNITS, 8'(units));
		wr_en <= 1'b0;
	endtask

	task automatic random_traffic(input int count, input bit calm);
		scene_t       sc [3];
		mag_reading_t r;
		logic [31:0]  pair;
		int           seg_left;
		int           span;
		seg_left = 0;
		repeat (count) begin
			if (seg_left == 0) begin
				span = sb.run_req;
				for (int a = 0; a < 3; a++) sc[a] = calm ? SCENE_QUIET : pick_scene();
				if ($urandom_range(0, 4) != 0) begin
					sc[1] = sc[0];
					sc[2] = sc[0];
				end
				seg_left = ($urandom_range(0, 7) == 0) ? $urandom_range(span + 1, 2 * span + 20) :
						$urandom_range(1, span + 6);
			end
			seg_left--;
			for (int a = 0; a < 3; a++) begin
				pair      = axis_pair(sc[a]);
				r.smp[a]  = pair[31:16];
				r.base[a] = pair[15:0];
			end
			offer_reading(r);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		burst_left = $urandom_range(1, 40);

		// Amplitude boundary and extreme values while the reset holdoff is still running.
		offer_reading(reading_of(-32768, 32767, 0, 0, -32768, 0));
		offer_reading(reading_of(32767, -32768, -32768, -32768, 32767, -32768));
		offer_reading(reading_of(250, -250, 251, 0, 0, 0));
		offer_reading(reading_of(-251, 0, 1000, 0, -251, -749));
		offer_reading(reading_of(0, 0, 0, 0, 0, 0));
		offer_reading(reading_of(32767, 32767, 32767, 32767, 32767, 32767));
		offer_reading(reading_of(-32768, -32768, -32768, 32767, 32767, 32767));
		offer_reading(reading_of(21845, -21846, 0, -21845, 21846, 0));

		// Zero required run: burn off the holdoff, then single samples switch modes.
		program_cfg(30, 15, 0, 0);
		random_traffic(80, 1'b1);
		offer_reading(reading_of(1040, -2040, 40, 1000, 2000, 0));
		offer_reading(reading_of(-1100, 2100, -32768, 1000, 2000, -32600));
		offer_reading(reading_of(1000, 2000, 0, 1000, 2000, 0));
		offer_reading(reading_of(1040, 2000, 0, 1000, 2000, 0));
		offer_reading(reading_of(1020, 2040, 0, 1000, 2000, 0));
		offer_reading(reading_of(1020, 2020, 40, 1000, 2000, 0));
		offer_reading(reading_of(1000, 2300, 1000, 1000, 2000, 0));
		offer_reading(reading_of(1000, 2000, 0, 1000, 2000, 0));

		program_cfg(30, 15, 4, 0);
		random_traffic(220, 1'b0);
		program_cfg(0, 255, 0, 0);
		random_traffic(120, 1'b0);
		program_cfg(200, 100, 2, 1);
		random_traffic(150, 1'b0);
		program_cfg($urandom_range(20, 120), $urandom_range(5, 20), $urandom_range(0, 8),
				$urandom_range(0, 1));
		random_traffic(200, 1'b0);
		program_cfg(10, 5, 255, 0);
		random_traffic(320, 1'b0);
		program_cfg(255, 0, 255, 255);
		random_traffic(60, 1'b0);
		program_cfg(50, 40, 1, 0);
		random_traffic(150, 1'b0);

		settle_block();
		if (sb.failures() == 0) begin
			$display("vehicle_detect_three_axis test passed");
		end else begin
			$display("vehicle_detect_three_axis test failed");
		end
		$finish;
	end

	initial begin
		#8000000;
		$display("vehicle_detect_three_axis test failed");
		$finish;
	end

endmodule

### sim.f
hdl/vdta_pkg.sv
hdl/vdta_axis.sv
hdl/vehicle_detect_three_axis.sv
dv/testbench.sv
